// ===== hdl/ls2_pkg.sv =====
package ls2_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;

  localparam int CW  = COEF_WIDTH;
  // Magnitude width of den and num
  localparam int MW  = 2 * CW;
  // x dividend: |num| shifted left by the fraction bits
  localparam int XNW = MW + FRAC_BITS;
  localparam int X_W = 48;
  localparam int Y_W = 49;
  // |a0| * |x| and |c0| << FRAC_BITS
  localparam int PRW = CW + X_W;
  localparam int CTW = CW + FRAC_BITS;
  // Magnitude width of the y dividend
  localparam int YNW = ((PRW > CTW) ? PRW : CTW) + 1;
  // Compare widths for saturation
  localparam int XQW = (XNW > X_W) ? XNW : X_W;
  localparam int YQW = (YNW > Y_W) ? YNW : Y_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEN_ZERO = 2'd1;
  localparam logic [1:0] ST_B0_ZERO  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] a0;
    logic signed [CW-1:0] b0;
    logic signed [CW-1:0] c0;
    logic                 xneg;
    logic [1:0]           status;
  } xside_t;

  typedef struct packed {
    logic [X_W-1:0] x_value;
    logic           yneg;
    logic [1:0]     status;
  } yside_t;

endpackage

// ===== hdl/linear_system_2x2_solver.sv =====
// Solver for a0*x + b0*y = c0, a1*x + b1*y = c1, one system per transaction.
// Input channel: in_valid / in_stall with the six signed coefficients.
// Output channel: out_valid / out_stall with out_x_value, out_y_value
// (fixed point, FRAC_BITS fraction bits, saturated) and out_status
// (0 ok, 1 determinant zero, 2 first y coefficient zero; results 0 on error).
// Throughput: one system per cycle while the receiver does not stall. The
// pipeline holds the two restoring dividers, one quotient bit per pipeline
// stage (48 stages for x, 65 for y), plus products, determinant, saturation,
// back-substitution and the output register.
// The whole pipeline advances together; while out_valid is high and the
// receiver stalls, in_stall goes high and every stage holds, so nothing is
// lost or repeated. Empty stages travel as bubbles.
// Reset clears all valid bits; the output channel shows no transaction
// until a system has passed through.
module linear_system_2x2_solver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ls2_pkg::CW-1:0]   in_coef_a0,
  input  logic signed [ls2_pkg::CW-1:0]   in_coef_b0,
  input  logic signed [ls2_pkg::CW-1:0]   in_rhs_c0,
  input  logic signed [ls2_pkg::CW-1:0]   in_coef_a1,
  input  logic signed [ls2_pkg::CW-1:0]   in_coef_b1,
  input  logic signed [ls2_pkg::CW-1:0]   in_rhs_c1,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ls2_pkg::X_W-1:0]  out_x_value,
  output logic signed [ls2_pkg::Y_W-1:0]  out_y_value,
  output logic [1:0]                      out_status
);

  localparam int CW  = ls2_pkg::CW;
  localparam int MW  = ls2_pkg::MW;
  localparam int XNW = ls2_pkg::XNW;
  localparam int XW  = ls2_pkg::X_W;
  localparam int YW  = ls2_pkg::Y_W;
  localparam int PRW = ls2_pkg::PRW;
  localparam int CTW = ls2_pkg::CTW;
  localparam int YNW = ls2_pkg::YNW;
  localparam int XQW = ls2_pkg::XQW;
  localparam int YQW = ls2_pkg::YQW;
  localparam int FB  = ls2_pkg::FRAC_BITS;

  logic en;

  // Stage 1: cross products
  logic                 v1_r;
  logic signed [MW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [CW-1:0] a0_1_r, b0_1_r, c0_1_r;

  // Stage 2: determinant and numerator
  logic                 v2_r;
  logic signed [MW:0]   den_r, num_r;
  logic signed [CW-1:0] a0_2_r, b0_2_r, c0_2_r;

  // Stage 3: magnitudes into the x divider
  logic                 v3_r;
  logic [XNW-1:0]       xdvd_r;
  logic [MW-1:0]        xdvs_r;
  ls2_pkg::xside_t      xside_r;
  logic signed [MW:0]   den_abs, num_abs;
  ls2_pkg::xside_t      xside_nxt;

  // x divider output
  logic                 xq_vld;
  logic [XNW-1:0]       xq;
  ls2_pkg::xside_t      xq_side;

  // Stage 4: saturate x
  logic                 v4_r;
  logic [XW-1:0]        xm4_r;
  logic [XW-1:0]        xval4_r;
  logic                 xneg4_r;
  logic signed [CW-1:0] a0_4_r, b0_4_r, c0_4_r;
  logic [1:0]           st4_r;
  logic [XQW-1:0]       xqe, xlim_neg, xlim_pos, xsat;
  logic                 xneg_nxt;
  logic [XW-1:0]        xm_nxt;

  // Stage 5: back-substitution product
  logic                 v5_r;
  logic [PRW-1:0]       pt5_r;
  logic [CTW-1:0]       ct5_r;
  logic                 ptneg5_r, ctneg5_r, b0neg5_r;
  logic [CW-1:0]        b0abs5_r;
  logic [XW-1:0]        xval5_r;
  logic [1:0]           st5_r;
  logic signed [CW:0]   a0w, b0w, c0w;

  // Stage 6: signed terms
  logic                 v6_r;
  logic signed [YNW:0]  cts6_r, pts6_r;
  logic                 b0neg6_r;
  logic [CW-1:0]        b0abs6_r;
  logic [XW-1:0]        xval6_r;
  logic [1:0]           st6_r;
  logic signed [YNW:0]  ct_e, pt_e;

  // Stage 7: y numerator
  logic                 v7_r;
  logic signed [YNW:0]  yn7_r;
  logic                 b0neg7_r;
  logic [CW-1:0]        b0abs7_r;
  logic [XW-1:0]        xval7_r;
  logic [1:0]           st7_r;

  // Stage 8: magnitudes into the y divider
  logic                 v8_r;
  logic [YNW-1:0]       ydvd_r;
  logic [CW-1:0]        ydvs_r;
  ls2_pkg::yside_t      yside_r;
  logic signed [YNW:0]  yn_abs;

  // y divider output
  logic                 yq_vld;
  logic [YNW-1:0]       yq;
  ls2_pkg::yside_t      yq_side;

  // Output register
  logic                 out_vld_r;
  logic [XW-1:0]        out_x_r;
  logic [YW-1:0]        out_y_r;
  logic [1:0]           out_st_r;
  logic [YQW-1:0]       yqe, ylim_neg, ylim_pos, ysat;
  logic                 yneg_nxt;
  logic [YW-1:0]        ym_nxt;
  logic [YW-1:0]        yval_nxt;

  assign in_stall = out_vld_r && out_stall;
  assign en       = !in_stall;

  // Valid bits of the front, middle and output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= xq_vld;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      out_vld_r <= yq_vld;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= MW'(in_coef_a0) * MW'(in_coef_b1);
      p1_r   <= MW'(in_coef_a1) * MW'(in_coef_b0);
      p2_r   <= MW'(in_rhs_c0) * MW'(in_coef_b1);
      p3_r   <= MW'(in_rhs_c1) * MW'(in_coef_b0);
      a0_1_r <= in_coef_a0;
      b0_1_r <= in_coef_b0;
      c0_1_r <= in_rhs_c0;
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= (MW+1)'(p0_r) - (MW+1)'(p1_r);
      num_r  <= (MW+1)'(p2_r) - (MW+1)'(p3_r);
      a0_2_r <= a0_1_r;
      b0_2_r <= b0_1_r;
      c0_2_r <= c0_1_r;
    end
  end

  // Stage 3
  always_comb begin
    den_abs = den_r[MW] ? -den_r : den_r;
    num_abs = num_r[MW] ? -num_r : num_r;
    xside_nxt.a0   = a0_2_r;
    xside_nxt.b0   = b0_2_r;
    xside_nxt.c0   = c0_2_r;
    xside_nxt.xneg = num_r[MW] ^ den_r[MW];
    priority if (den_r == '0) begin
      xside_nxt.status = ls2_pkg::ST_DEN_ZERO;
    end else if (b0_2_r == '0) begin
      xside_nxt.status = ls2_pkg::ST_B0_ZERO;
    end else begin
      xside_nxt.status = ls2_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xdvd_r  <= XNW'(num_abs[MW-1:0]) << FB;
      xdvs_r  <= den_abs[MW-1:0];
      xside_r <= xside_nxt;
    end
  end

  ls2_xdiv u_xdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_dvd   (xdvd_r),
    .in_dvs   (xdvs_r),
    .in_side  (xside_r),
    .out_vld  (xq_vld),
    .out_quo  (xq),
    .out_side (xq_side)
  );

  // Stage 4: sign fix-up and saturation of x; zero on error
  always_comb begin
    xqe      = XQW'(xq);
    xlim_neg = XQW'(1) << (XW - 1);
    xlim_pos = xlim_neg - XQW'(1);
    xneg_nxt = xq_side.xneg && (xq != '0);
    if (xneg_nxt) begin
      xsat = (xqe > xlim_neg) ? xlim_neg : xqe;
    end else begin
      xsat = (xqe > xlim_pos) ? xlim_pos : xqe;
    end
    xm_nxt = xsat[XW-1:0];
    if (xq_side.status != ls2_pkg::ST_OK) begin
      xm_nxt   = '0;
      xneg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm4_r   <= xm_nxt;
      xneg4_r <= xneg_nxt;
      xval4_r <= xneg_nxt ? -xm_nxt : xm_nxt;
      a0_4_r  <= xq_side.a0;
      b0_4_r  <= xq_side.b0;
      c0_4_r  <= xq_side.c0;
      st4_r   <= xq_side.status;
    end
  end

  // Stage 5
  always_comb begin
    a0w = (CW+1)'(a0_4_r);
    b0w = (CW+1)'(b0_4_r);
    c0w = (CW+1)'(c0_4_r);
    if (a0w < 0) a0w = -a0w;
    if (b0w < 0) b0w = -b0w;
    if (c0w < 0) c0w = -c0w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt5_r    <= PRW'(a0w[CW-1:0]) * PRW'(xm4_r);
      ct5_r    <= CTW'(c0w[CW-1:0]) << FB;
      ptneg5_r <= a0_4_r[CW-1] ^ xneg4_r;
      ctneg5_r <= c0_4_r[CW-1];
      b0neg5_r <= b0_4_r[CW-1];
      b0abs5_r <= b0w[CW-1:0];
      xval5_r  <= xval4_r;
      st5_r    <= st4_r;
    end
  end

  // Stage 6
  always_comb begin
    ct_e = $signed((YNW+1)'(ct5_r));
    pt_e = $signed((YNW+1)'(pt5_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cts6_r   <= ctneg5_r ? -ct_e : ct_e;
      pts6_r   <= ptneg5_r ? -pt_e : pt_e;
      b0neg6_r <= b0neg5_r;
      b0abs6_r <= b0abs5_r;
      xval6_r  <= xval5_r;
      st6_r    <= st5_r;
    end
  end

  // Stage 7
  always_ff @(posedge clk) begin
    if (en) begin
      yn7_r    <= cts6_r - pts6_r;
      b0neg7_r <= b0neg6_r;
      b0abs7_r <= b0abs6_r;
      xval7_r  <= xval6_r;
      st7_r    <= st6_r;
    end
  end

  // Stage 8
  assign yn_abs = yn7_r[YNW] ? -yn7_r : yn7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ydvd_r          <= yn_abs[YNW-1:0];
      ydvs_r          <= b0abs7_r;
      yside_r.x_value <= xval7_r;
      yside_r.yneg    <= yn7_r[YNW] ^ b0neg7_r;
      yside_r.status  <= st7_r;
    end
  end

  ls2_ydiv u_ydiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_dvd   (ydvd_r),
    .in_dvs   (ydvs_r),
    .in_side  (yside_r),
    .out_vld  (yq_vld),
    .out_quo  (yq),
    .out_side (yq_side)
  );

  // Output stage: saturate y, drop results on error
  always_comb begin
    yqe      = YQW'(yq);
    ylim_neg = YQW'(1) << (YW - 1);
    ylim_pos = ylim_neg - YQW'(1);
    yneg_nxt = yq_side.yneg && (yq != '0);
    if (yneg_nxt) begin
      ysat = (yqe > ylim_neg) ? ylim_neg : yqe;
    end else begin
      ysat = (yqe > ylim_pos) ? ylim_pos : yqe;
    end
    ym_nxt   = ysat[YW-1:0];
    yval_nxt = yneg_nxt ? -ym_nxt : ym_nxt;
    if (yq_side.status != ls2_pkg::ST_OK) begin
      yval_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r  <= yq_side.x_value;
      out_y_r  <= yval_nxt;
      out_st_r <= yq_side.status;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_x_value = out_x_r;
  assign out_y_value = out_y_r;
  assign out_status  = out_st_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_st_r != ls2_pkg::ST_OK) |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("nonzero result on error status");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_vld_r)
    else $error("output valid right after reset");

  a_xsat: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (xm4_r <= (XW'(1) << (XW - 1))))
    else $error("x magnitude beyond saturation limit");
`endif

endmodule

// ===== hdl/ls2_xdiv.sv =====
module ls2_xdiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ls2_pkg::XNW-1:0]  in_dvd,
  input  logic [ls2_pkg::MW-1:0]   in_dvs,
  input  ls2_pkg::xside_t          in_side,
  output logic                     out_vld,
  output logic [ls2_pkg::XNW-1:0]  out_quo,
  output ls2_pkg::xside_t          out_side
);

  localparam int N = ls2_pkg::XNW;
  localparam int D = ls2_pkg::MW;

  logic            vld_r  [N];
  logic [D-1:0]    rem_r  [N];
  logic [N-1:0]    dvd_r  [N];
  logic [N-1:0]    quo_r  [N];
  logic [D-1:0]    dvs_r  [N];
  ls2_pkg::xside_t side_r [N];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            s_vld;
    logic [D-1:0]    s_rem;
    logic [N-1:0]    s_dvd;
    logic [N-1:0]    s_quo;
    logic [D-1:0]    s_dvs;
    ls2_pkg::xside_t s_side;
    logic [D:0]      t;
    logic [D:0]      diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign s_vld  = in_vld;
      assign s_rem  = '0;
      assign s_dvd  = in_dvd;
      assign s_quo  = '0;
      assign s_dvs  = in_dvs;
      assign s_side = in_side;
    end else begin : g_next
      assign s_vld  = vld_r[k-1];
      assign s_rem  = rem_r[k-1];
      assign s_dvd  = dvd_r[k-1];
      assign s_quo  = quo_r[k-1];
      assign s_dvs  = dvs_r[k-1];
      assign s_side = side_r[k-1];
    end

    assign t    = {s_rem, s_dvd[N-1]};
    assign ge   = t >= {1'b0, s_dvs};
    assign diff = t - {1'b0, s_dvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[D-1:0] : t[D-1:0];
        dvd_r[k]  <= {s_dvd[N-2:0], 1'b0};
        quo_r[k]  <= {s_quo[N-2:0], ge};
        dvs_r[k]  <= s_dvs;
        side_r[k] <= s_side;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_quo  = quo_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== hdl/ls2_ydiv.sv =====
module ls2_ydiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ls2_pkg::YNW-1:0]  in_dvd,
  input  logic [ls2_pkg::CW-1:0]   in_dvs,
  input  ls2_pkg::yside_t          in_side,
  output logic                     out_vld,
  output logic [ls2_pkg::YNW-1:0]  out_quo,
  output ls2_pkg::yside_t          out_side
);

  localparam int N = ls2_pkg::YNW;
  localparam int D = ls2_pkg::CW;

  logic            vld_r  [N];
  logic [D-1:0]    rem_r  [N];
  logic [N-1:0]    dvd_r  [N];
  logic [N-1:0]    quo_r  [N];
  logic [D-1:0]    dvs_r  [N];
  ls2_pkg::yside_t side_r [N];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            s_vld;
    logic [D-1:0]    s_rem;
    logic [N-1:0]    s_dvd;
    logic [N-1:0]    s_quo;
    logic [D-1:0]    s_dvs;
    ls2_pkg::yside_t s_side;
    logic [D:0]      t;
    logic [D:0]      diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign s_vld  = in_vld;
      assign s_rem  = '0;
      assign s_dvd  = in_dvd;
      assign s_quo  = '0;
      assign s_dvs  = in_dvs;
      assign s_side = in_side;
    end else begin : g_next
      assign s_vld  = vld_r[k-1];
      assign s_rem  = rem_r[k-1];
      assign s_dvd  = dvd_r[k-1];
      assign s_quo  = quo_r[k-1];
      assign s_dvs  = dvs_r[k-1];
      assign s_side = side_r[k-1];
    end

    assign t    = {s_rem, s_dvd[N-1]};
    assign ge   = t >= {1'b0, s_dvs};
    assign diff = t - {1'b0, s_dvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[D-1:0] : t[D-1:0];
        dvd_r[k]  <= {s_dvd[N-2:0], 1'b0};
        quo_r[k]  <= {s_quo[N-2:0], ge};
        dvs_r[k]  <= s_dvs;
        side_r[k] <= s_side;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_quo  = quo_r[N-1];
  assign out_side = side_r[N-1];

endmodule
